FILE: src/led_blink_breathe_pattern_unit_assert.svh
// Assertion macros for the LED pattern unit.
// Used by led_blink_breathe_pattern_unit.sv; expects clk and arst_n in scope.
`ifndef LED_BLINK_BREATHE_PATTERN_UNIT_ASSERT_SVH
`define LED_BLINK_BREATHE_PATTERN_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBBP_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LBBP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/lbbp_pkg.sv
// Shared types, constants and brightness tables of the LED pattern unit.
// No dependencies; used by lbbp_step_logic, the top level and the testbench.
`timescale 1ns / 1ps

package lbbp_pkg;

	// Pattern modes as written to the mode register.
	typedef enum logic [1:0] {
		MODE_OFF   = 2'd0,
		MODE_ON    = 2'd1,
		MODE_BLINK = 2'd2,
		MODE_PULSE = 2'd3
	} mode_t;

	// Configuration register indexes.
	typedef enum logic [1:0] {
		REG_PATTERN_MODE = 2'd0,
		REG_LED_COLOR    = 2'd1,
		REG_CYCLE_LIMIT  = 2'd2,
		REG_BLINK_HALF   = 2'd3
	} reg_idx_t;

	localparam int unsigned BREATH_SPAN_MS   = 2800;
	localparam int unsigned PWM_CLK_PER_MS   = 128;
	localparam int unsigned MAX_TICK_MS      = 10;
	localparam int unsigned GREEN_STEPS      = 48;
	localparam int unsigned RED_STEPS        = 47;
	localparam logic [7:0]  FULL_DUTY        = 8'd255;
	localparam logic [15:0] BLINK_HALF_RESET = 16'd250;

	localparam int unsigned BREATH_SPAN_PWM = BREATH_SPAN_MS * PWM_CLK_PER_MS;
	localparam int unsigned GREEN_BASE   = BREATH_SPAN_PWM / GREEN_STEPS;
	localparam int unsigned GREEN_REM    = BREATH_SPAN_PWM % GREEN_STEPS;
	localparam int unsigned RED_BASE     = BREATH_SPAN_PWM / RED_STEPS;
	localparam int unsigned RED_REM      = BREATH_SPAN_PWM % RED_STEPS;
	localparam int unsigned MAX_BASE     = (GREEN_BASE > RED_BASE) ? GREEN_BASE : RED_BASE;
	localparam int unsigned TICK_CAP_PWM = MAX_TICK_MS * PWM_CLK_PER_MS;

	localparam int unsigned IDX_W   = 6;
	localparam int unsigned CARRY_W = 6;
	localparam int unsigned TICK_W  = $clog2(TICK_CAP_PWM + 1);
	// The step counter stays below one step spacing plus one tick's worth.
	localparam int unsigned TSS_W   = $clog2(MAX_BASE + 2 + TICK_CAP_PWM);

	localparam logic [7:0] GREEN_ENV [GREEN_STEPS] = '{
		8'd1, 8'd1, 8'd2, 8'd3, 8'd5, 8'd8, 8'd12, 8'd17, 8'd23, 8'd30, 8'd38, 8'd47,
		8'd57, 8'd68, 8'd80, 8'd93, 8'd107, 8'd122, 8'd138, 8'd155, 8'd173, 8'd192,
		8'd212, 8'd233, 8'd255, 8'd233, 8'd212, 8'd192, 8'd173, 8'd155, 8'd138,
		8'd122, 8'd107, 8'd93, 8'd80, 8'd68, 8'd57, 8'd47, 8'd38, 8'd30, 8'd23,
		8'd17, 8'd12, 8'd8, 8'd5, 8'd3, 8'd2, 8'd1
	};

	localparam logic [7:0] RED_ENV [RED_STEPS] = '{
		8'd1, 8'd2, 8'd4, 8'd7, 8'd11, 8'd16, 8'd22, 8'd29, 8'd37, 8'd46, 8'd56, 8'd67,
		8'd79, 8'd92, 8'd106, 8'd121, 8'd137, 8'd154, 8'd172, 8'd191, 8'd211, 8'd232,
		8'd248, 8'd255, 8'd248, 8'd232, 8'd211, 8'd191, 8'd172, 8'd154, 8'd137,
		8'd121, 8'd106, 8'd92, 8'd79, 8'd67, 8'd56, 8'd46, 8'd37, 8'd29, 8'd22,
		8'd16, 8'd11, 8'd7, 8'd4, 8'd2, 8'd1
	};

	typedef struct packed {
		mode_t       pattern_mode;
		logic        led_color;
		logic [15:0] cycle_limit;
		logic [15:0] blink_half_period_ms;
	} cfg_t;

	typedef struct packed {
		mode_t              active_mode;
		logic               lit_flag;
		logic [15:0]        blink_ms_count;
		logic [15:0]        cycles_done;
		logic [IDX_W-1:0]   table_index;
		logic               index_rising;
		logic [TSS_W-1:0]   ticks_since_step;
		logic [CARRY_W-1:0] remainder_carry;
	} state_t;

	typedef struct packed {
		logic       led_lit;
		logic       drive_color;
		logic [7:0] duty;
		logic       pattern_done;
	} result_t;

	// Number of table entries for the selected color.
	function automatic logic [IDX_W-1:0] table_steps(input logic color);
		return color ? IDX_W'(RED_STEPS) : IDX_W'(GREEN_STEPS);
	endfunction

	// Brightness table lookup; entries past the end read as dark.
	function automatic logic [7:0] env_duty(input logic color, input logic [IDX_W-1:0] idx);
		logic [7:0] val;
		val = 8'd0;
		if (color) begin
			if (idx < IDX_W'(RED_STEPS)) val = RED_ENV[idx];
		end else begin
			if (idx < IDX_W'(GREEN_STEPS)) val = GREEN_ENV[idx];
		end
		return val;
	endfunction

endpackage

FILE: src/led_blink_breathe_pattern_unit.sv
// A tick beat is registered in the input stage, then its result in the result register.
// Throughput: one tick beat per cycle while results are taken; the input stage refills
// while a result waits. The rate is set by the single pass through lbbp_step_logic between them.
// Reset (arst_n low, asynchronous): pattern off, blink half period 250 ms, counters zero.
// Configuration writes are accepted in every cycle and restart the pattern.
`timescale 1ns / 1ps
`include "led_blink_breathe_pattern_unit_assert.svh"

module led_blink_breathe_pattern_unit (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// Tick channel.
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  elapsed_ms,
	// Result channel.
	output logic        out_valid,
	input  logic        out_ready,
	output logic        led_lit,
	output logic        drive_color,
	output logic [7:0]  duty,
	output logic        pattern_done
);

	// Configuration registers and the pattern state they restart.
	lbbp_pkg::cfg_t    cfg_q;
	lbbp_pkg::cfg_t    cfg_next;
	lbbp_pkg::state_t  state_q;
	lbbp_pkg::state_t  state_restart;
	lbbp_pkg::state_t  state_step;
	lbbp_pkg::result_t res_step;
	lbbp_pkg::result_t res_q;

	// Input stage holding one tick beat.
	logic       valid_s1;
	logic [3:0] ms_s1;
	logic       out_valid_q;

	logic cfg_write;
	logic advance;

	// The configuration port never stalls; the user must write only while idle, which the block does not enforce.
	assign cfg_ready = 1'b1;
	assign cfg_write = cfg_valid && cfg_ready;

	// The input stage moves into the result register whenever that register is
	// empty or its beat is being taken in this cycle.
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// Apply the incoming write to form the register values after this edge.
	always_comb begin
		cfg_next = cfg_q;
		if (cfg_write) begin
			unique case (cfg_index)
				lbbp_pkg::REG_PATTERN_MODE: cfg_next.pattern_mode = lbbp_pkg::mode_t'(cfg_data[1:0]);
				lbbp_pkg::REG_LED_COLOR:    cfg_next.led_color = cfg_data[0];
				lbbp_pkg::REG_CYCLE_LIMIT:  cfg_next.cycle_limit = cfg_data;
				lbbp_pkg::REG_BLINK_HALF:   cfg_next.blink_half_period_ms = cfg_data;
				default:                    cfg_next = cfg_q;
			endcase
		end
	end

	// Restart state: all counters clear; steady on and pulse start lit, and the
	// pulse starts at the last entry of its table, stepping down the index.
	always_comb begin
		state_restart             = '0;
		state_restart.active_mode = cfg_next.pattern_mode;
		state_restart.lit_flag    = (cfg_next.pattern_mode == lbbp_pkg::MODE_ON) ||
		                            (cfg_next.pattern_mode == lbbp_pkg::MODE_PULSE);
		if (cfg_next.pattern_mode == lbbp_pkg::MODE_PULSE) begin
			state_restart.table_index = lbbp_pkg::table_steps(cfg_next.led_color) -
			                            lbbp_pkg::IDX_W'(1);
		end
	end

	lbbp_step_logic u_step (
		.cfg        (cfg_q),
		.cur        (state_q),
		.elapsed_ms (ms_s1),
		.nxt        (state_step),
		.res        (res_step)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_mode         <= lbbp_pkg::MODE_OFF;
			cfg_q.led_color            <= 1'b0;
			cfg_q.cycle_limit          <= 16'd0;
			cfg_q.blink_half_period_ms <= lbbp_pkg::BLINK_HALF_RESET;
			state_q                    <= '0;
		end else if (cfg_write) begin
			cfg_q   <= cfg_next;
			state_q <= state_restart;
		end else if (advance) begin
			state_q <= state_step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) valid_s1 <= in_valid;
			if (advance) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) ms_s1 <= elapsed_ms;
		if (advance) res_q <= res_step;
	end

	assign out_valid    = out_valid_q;
	assign led_lit      = res_q.led_lit;
	assign drive_color  = res_q.drive_color;
	assign duty         = res_q.duty;
	assign pattern_done = res_q.pattern_done;

	// A waiting tick beat must not be dropped while the result is stalled.
	`LBBP_ASSERT_NEXT(a_hold_s1, valid_s1 && out_valid_q && !out_ready && !cfg_write, valid_s1, "tick beat lost during stall")

	// A dark result never carries brightness.
	`LBBP_ASSERT_NOW(a_dark_duty, out_valid_q && !res_q.led_lit, res_q.duty == 8'd0, "dark result with nonzero duty")

	// A finished pattern always reports dark.
	`LBBP_ASSERT_NOW(a_done_dark, out_valid_q && res_q.pattern_done, !res_q.led_lit, "finished pattern reported lit")

	// The table index stays inside the table of the selected color.
	`LBBP_ASSERT_NOW(a_idx_range, state_q.active_mode == lbbp_pkg::MODE_PULSE, state_q.table_index < lbbp_pkg::table_steps(cfg_q.led_color), "table index out of range")

	// The step carry stays below the table length.
	`LBBP_ASSERT_NOW(a_carry_range, state_q.active_mode == lbbp_pkg::MODE_PULSE, lbbp_pkg::IDX_W'(state_q.remainder_carry) < lbbp_pkg::table_steps(cfg_q.led_color), "remainder carry out of range")

endmodule

FILE: src/lbbp_step_logic.sv
// Next-state and result logic for one tick of the LED pattern unit.
// Purely combinational; depends on lbbp_pkg.
`timescale 1ns / 1ps

module lbbp_step_logic (
	input  lbbp_pkg::cfg_t    cfg,
	input  lbbp_pkg::state_t  cur,
	input  logic [3:0]        elapsed_ms,
	output lbbp_pkg::state_t  nxt,
	output lbbp_pkg::result_t res
);

	logic [15:0]                  cyc_inc;
	logic                         limit_on;
	logic                         limit_hit;
	logic [16:0]                  blink_sum;
	logic [3:0]                   ms_cap;
	logic [lbbp_pkg::TICK_W-1:0]  ticks;
	logic [lbbp_pkg::IDX_W-1:0]   steps;
	logic [lbbp_pkg::TSS_W-1:0]   base;
	logic [lbbp_pkg::CARRY_W-1:0] rem;
	logic [lbbp_pkg::TSS_W-1:0]   tss_sum;
	logic [lbbp_pkg::CARRY_W:0]   carry_sum;
	logic                         wrap;
	logic [lbbp_pkg::CARRY_W-1:0] carry_new;
	logic [lbbp_pkg::TSS_W-1:0]   need;
	logic                         fire;
	logic [lbbp_pkg::IDX_W-1:0]   idx_step;
	logic                         at_low;
	logic                         at_high;
	logic [7:0]                   duty_v;

	// Cycle counting shared by blink and pulse.
	assign cyc_inc   = cur.cycles_done + 16'd1;
	assign limit_on  = (cfg.cycle_limit != 16'd0);
	assign limit_hit = limit_on && (cyc_inc >= cfg.cycle_limit);

	assign blink_sum = {1'b0, cur.blink_ms_count} + 17'(elapsed_ms);

	// Pulse step spacing: whole PWM ticks plus a fractional carry.
	assign ms_cap  = (elapsed_ms > 4'(lbbp_pkg::MAX_TICK_MS)) ? 4'(lbbp_pkg::MAX_TICK_MS)
	                                                         : elapsed_ms;
	assign ticks   = lbbp_pkg::TICK_W'(lbbp_pkg::TICK_W'(ms_cap) *
	                                   lbbp_pkg::TICK_W'(lbbp_pkg::PWM_CLK_PER_MS));
	assign steps   = lbbp_pkg::table_steps(cfg.led_color);
	assign base    = cfg.led_color ? lbbp_pkg::TSS_W'(lbbp_pkg::RED_BASE)
	                               : lbbp_pkg::TSS_W'(lbbp_pkg::GREEN_BASE);
	assign rem     = cfg.led_color ? lbbp_pkg::CARRY_W'(lbbp_pkg::RED_REM)
	                               : lbbp_pkg::CARRY_W'(lbbp_pkg::GREEN_REM);
	assign tss_sum = cur.ticks_since_step + lbbp_pkg::TSS_W'(ticks);

	assign carry_sum = {1'b0, cur.remainder_carry} + {1'b0, rem};
	assign wrap      = (carry_sum >= {1'b0, steps});
	assign carry_new = wrap ? lbbp_pkg::CARRY_W'(carry_sum - {1'b0, steps})
	                        : lbbp_pkg::CARRY_W'(carry_sum);

	always_comb begin
		need = base + lbbp_pkg::TSS_W'(wrap);
		if (need == '0) need = lbbp_pkg::TSS_W'(1);
	end

	assign fire = (tss_sum >= need);

	// The index bounces at both ends of the table.
	always_comb begin
		idx_step = cur.index_rising ? cur.table_index + lbbp_pkg::IDX_W'(1)
		                            : cur.table_index - lbbp_pkg::IDX_W'(1);
		if (idx_step >= steps) idx_step = steps - lbbp_pkg::IDX_W'(1);
	end

	assign at_low  = (idx_step == '0);
	assign at_high = (idx_step == steps - lbbp_pkg::IDX_W'(1));

	always_comb begin
		nxt    = cur;
		duty_v = 8'd0;
		unique case (cur.active_mode)
			lbbp_pkg::MODE_OFF: begin
				nxt.lit_flag = 1'b0;
			end
			lbbp_pkg::MODE_ON: begin
				nxt.lit_flag = 1'b1;
				duty_v       = lbbp_pkg::FULL_DUTY;
			end
			lbbp_pkg::MODE_BLINK: begin
				if (blink_sum >= {1'b0, cfg.blink_half_period_ms}) begin
					nxt.lit_flag       = !cur.lit_flag;
					nxt.blink_ms_count = 16'd0;
					// An on-to-off edge closes one blink cycle.
					if (cur.lit_flag && limit_on) begin
						nxt.cycles_done = cyc_inc;
						if (limit_hit) begin
							nxt.active_mode = lbbp_pkg::MODE_OFF;
							nxt.lit_flag    = 1'b0;
						end
					end
				end else begin
					nxt.blink_ms_count = blink_sum[15:0];
				end
				duty_v = lbbp_pkg::FULL_DUTY;
			end
			lbbp_pkg::MODE_PULSE: begin
				nxt.lit_flag         = 1'b1;
				nxt.ticks_since_step = tss_sum;
				if (fire) begin
					nxt.ticks_since_step = tss_sum - need;
					nxt.remainder_carry  = carry_new;
					nxt.table_index      = idx_step;
					if (at_low || at_high) nxt.index_rising = !cur.index_rising;
					// Arriving at the bottom of the table closes one pulse cycle.
					if (at_low && limit_on) begin
						nxt.cycles_done = cyc_inc;
						if (limit_hit) begin
							nxt.active_mode = lbbp_pkg::MODE_OFF;
							nxt.lit_flag    = 1'b0;
						end
					end
				end
				duty_v = lbbp_pkg::env_duty(cfg.led_color, nxt.table_index);
			end
		endcase

		res.led_lit      = nxt.lit_flag;
		res.drive_color  = cfg.led_color;
		res.duty         = nxt.lit_flag ? duty_v : 8'd0;
		res.pattern_done = (nxt.active_mode == lbbp_pkg::MODE_OFF) &&
		                   (cfg.pattern_mode != lbbp_pkg::MODE_OFF);
	end

endmodule

FILE: dv/lbbp_drive_checker.sv
// Checker for the LED pattern unit: watches the config, tick and result channels.
// Predicts the LED drive after every accepted tick and compares result beats in order.
// Depends on lbbp_pkg for the mode and register enums, the result struct and the tables.
`timescale 1ns / 1ps

module lbbp_drive_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  elapsed_ms,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        led_lit,
	input  logic        drive_color,
	input  logic [7:0]  duty,
	input  logic        pattern_done,
	output int unsigned drive_mismatches,
	output int unsigned awaited_count
);

	// Register copies.
	lbbp_pkg::mode_t cfg_mode;
	logic            cfg_color;
	logic [15:0]     cfg_limit;
	logic [15:0]     cfg_half;

	// Pattern state.
	lbbp_pkg::mode_t live_mode;
	logic            lit;
	logic [15:0]     blink_ms;
	logic [15:0]     cycles_done;
	logic [5:0]      env_idx;
	logic            env_rising;
	int unsigned     pwm_ticks;
	int unsigned     step_carry;

	lbbp_pkg::result_t awaited_drive [$];
	lbbp_pkg::result_t oldest;
	lbbp_pkg::result_t seen;

	function automatic void restart_pattern();
		live_mode = cfg_mode;
		lit = 1'b0;
		blink_ms = 16'd0;
		cycles_done = 16'd0;
		env_idx = 6'd0;
		env_rising = 1'b0;
		pwm_ticks = 0;
		step_carry = 0;
		if (live_mode == lbbp_pkg::MODE_ON) begin
			lit = 1'b1;
		end else if (live_mode == lbbp_pkg::MODE_PULSE) begin
			lit = 1'b1;
			env_idx = cfg_color ? 6'(lbbp_pkg::RED_STEPS - 1)
			                    : 6'(lbbp_pkg::GREEN_STEPS - 1);
		end
	endfunction

	// A finished cycle; returns 1 when the limit forces the pattern off.
	function automatic bit finish_cycle();
		if (cfg_limit == 16'd0)
			return 1'b0;
		cycles_done = cycles_done + 16'd1;
		if (cycles_done >= cfg_limit) begin
			live_mode = lbbp_pkg::MODE_OFF;
			lit = 1'b0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic lbbp_pkg::result_t led_drive_after_tick(input logic [3:0] ms);
		lbbp_pkg::result_t r;
		logic [16:0]       ms_sum;
		int unsigned       n_steps;
		int unsigned       base_ticks;
		int unsigned       rem_ticks;
		int unsigned       carry;
		int unsigned       need;
		bit                stopped;
		bit                stepping;
		r = '0;
		case (live_mode)
			lbbp_pkg::MODE_OFF: begin
				lit = 1'b0;
			end
			lbbp_pkg::MODE_ON: begin
				lit = 1'b1;
				r.duty = lbbp_pkg::FULL_DUTY;
			end
			lbbp_pkg::MODE_BLINK: begin
				ms_sum = {1'b0, blink_ms} + 17'(ms);
				if (ms_sum > 17'h0FFFF)
					ms_sum = 17'h0FFFF;
				blink_ms = ms_sum[15:0];
				if (blink_ms >= cfg_half) begin
					lit = !lit;
					blink_ms = 16'd0;
					if (!lit)
						void'(finish_cycle());
				end
				r.duty = lit ? lbbp_pkg::FULL_DUTY : 8'd0;
			end
			default: begin
				n_steps = cfg_color ? lbbp_pkg::RED_STEPS : lbbp_pkg::GREEN_STEPS;
				base_ticks = lbbp_pkg::BREATH_SPAN_PWM / n_steps;
				rem_ticks = lbbp_pkg::BREATH_SPAN_PWM % n_steps;
				pwm_ticks += ((ms > lbbp_pkg::MAX_TICK_MS) ? lbbp_pkg::MAX_TICK_MS : ms) *
					lbbp_pkg::PWM_CLK_PER_MS;
				stopped = 1'b0;
				stepping = 1'b1;
				while (stepping) begin
					carry = step_carry + rem_ticks;
					need = base_ticks;
					if (carry >= n_steps) begin
						carry -= n_steps;
						need += 1;
					end
					if (need == 0)
						need = 1;
					if (pwm_ticks < need) begin
						stepping = 1'b0;
					end else begin
						pwm_ticks -= need;
						step_carry = carry;
						env_idx = env_rising ? env_idx + 6'd1 : env_idx - 6'd1;
						if (env_idx >= n_steps)
							env_idx = 6'(n_steps - 1);
						if (env_idx == 6'd0 || env_idx == 6'(n_steps - 1)) begin
							env_rising = !env_rising;
							if (env_idx == 6'd0 && finish_cycle()) begin
								stopped = 1'b1;
								stepping = 1'b0;
							end
						end
					end
				end
				if (!stopped) begin
					lit = 1'b1;
					r.duty = cfg_color ? lbbp_pkg::RED_ENV[env_idx]
					                   : lbbp_pkg::GREEN_ENV[env_idx];
				end
			end
		endcase
		if (!lit)
			r.duty = 8'd0;
		r.led_lit = lit;
		r.drive_color = cfg_color;
		r.pattern_done = (live_mode == lbbp_pkg::MODE_OFF) &&
			(cfg_mode != lbbp_pkg::MODE_OFF);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_mode = lbbp_pkg::MODE_OFF;
			cfg_color = 1'b0;
			cfg_limit = 16'd0;
			cfg_half = lbbp_pkg::BLINK_HALF_RESET;
			restart_pattern();
			awaited_drive.delete();
			drive_mismatches = 0;
			awaited_count = 0;
		end else begin
			if (out_valid && out_ready) begin
				seen = '{led_lit: led_lit, drive_color: drive_color, duty: duty,
					pattern_done: pattern_done};
				if (awaited_drive.size() == 0) begin
					drive_mismatches++;
					if (drive_mismatches <= 10)
						$display({"result beat with no tick outstanding: ",
							"lit=%0d color=%0d duty=%0d done=%0d"},
							seen.led_lit, seen.drive_color, seen.duty, seen.pattern_done);
				end else begin
					oldest = awaited_drive.pop_front();
					if (seen !== oldest) begin
						drive_mismatches++;
						if (drive_mismatches <= 10)
							$display({"drive mismatch: expected lit=%0d color=%0d ",
								"duty=%0d done=%0d, got lit=%0d color=%0d duty=%0d done=%0d"},
								oldest.led_lit, oldest.drive_color, oldest.duty,
								oldest.pattern_done, seen.led_lit, seen.drive_color,
								seen.duty, seen.pattern_done);
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (lbbp_pkg::reg_idx_t'(cfg_index))
					lbbp_pkg::REG_PATTERN_MODE: cfg_mode = lbbp_pkg::mode_t'(cfg_data[1:0]);
					lbbp_pkg::REG_LED_COLOR:    cfg_color = cfg_data[0];
					lbbp_pkg::REG_CYCLE_LIMIT:  cfg_limit = cfg_data;
					lbbp_pkg::REG_BLINK_HALF:   cfg_half = cfg_data;
				endcase
				restart_pattern();
			end
			if (in_valid && in_ready)
				awaited_drive.push_back(led_drive_after_tick(elapsed_ms));
			awaited_count = awaited_drive.size();
		end
	end

endmodule

FILE: dv/led_blink_breathe_pattern_unit_test.sv
// Top of the LED pattern unit testbench: clock, reset, config writes, tick and result traffic.
// Depends on lbbp_pkg, the led_blink_breathe_pattern_unit RTL and lbbp_drive_checker.
`timescale 1ns / 1ps

module led_blink_breathe_pattern_unit_test;

	// Longest stretch without any accepted beat before the run is declared hung.
	localparam int unsigned QUIET_LIMIT = 5000;
	// Length of the deliberate result-side stall that backs the block up.
	localparam int unsigned HOLD_CYCLES = 300;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  elapsed_ms;
	logic        out_valid;
	logic        out_ready;
	logic        led_lit;
	logic        drive_color;
	logic [7:0]  duty;
	logic        pattern_done;

	int unsigned drive_mismatches;
	int unsigned awaited_count;
	int unsigned src_idle_pct;
	int unsigned sink_idle_pct;
	int unsigned quiet_cycles;
	bit          hold_request;

	led_blink_breathe_pattern_unit u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.elapsed_ms   (elapsed_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.led_lit      (led_lit),
		.drive_color  (drive_color),
		.duty         (duty),
		.pattern_done (pattern_done)
	);

	// The checker sees every channel exactly as the block does and keeps the
	// only copy of the expected drive values; the top just reads its counts.
	lbbp_drive_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.elapsed_ms       (elapsed_ms),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.led_lit          (led_lit),
		.drive_color      (drive_color),
		.duty             (duty),
		.pattern_done     (pattern_done),
		.drive_mismatches (drive_mismatches),
		.awaited_count    (awaited_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side. Ready is redrawn every cycle from the current idle rate. When
	// a hold is requested, ready stays low for a long stretch so that the block
	// fills up and has to push back on the tick channel.
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// Hang detection: any accepted beat on any channel resets the count. The
	// values read here are the ones present just before the edge.
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((cfg_valid && cfg_ready) || (in_valid && in_ready) ||
				(out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= QUIET_LIMIT) begin
				$display("timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
				$display("led_blink_breathe_pattern_unit_test NOT OK");
				$finish;
			end
		end
	end

	// All drivers below are entered right after a rising edge and leave right
	// after the edge that accepted their beat. Ready is looked at on the falling
	// edge, where nothing is changing, so acceptance never races the block.
	// Valid is left high on exit so back-to-back beats need no second update
	// in the same step; the caller lowers it once the burst is over.
	task automatic write_reg(input lbbp_pkg::reg_idx_t idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
	endtask

	// Writes all four registers. Each write restarts the pattern, so the last
	// one leaves it freshly started with the full setting. Unused upper data
	// bits of the narrow registers carry random values.
	task automatic set_pattern(input lbbp_pkg::mode_t mode, input logic color,
			input logic [15:0] limit, input logic [15:0] half);
		write_reg(lbbp_pkg::REG_PATTERN_MODE, {14'($urandom), mode});
		write_reg(lbbp_pkg::REG_LED_COLOR, {15'($urandom), color});
		write_reg(lbbp_pkg::REG_CYCLE_LIMIT, limit);
		write_reg(lbbp_pkg::REG_BLINK_HALF, half);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_tick(input logic [3:0] ms);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < src_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		elapsed_ms <= ms;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	// Stops offering ticks and waits until every result beat has come back, so
	// that the next register write lands on an idle block.
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (awaited_count != 0);
		@(posedge clk);
	endtask

	// Mostly in-range tick lengths; one in ten is drawn from the full range, which holds zero
	// and lengths above the ten millisecond cap. Pulse phases lean on long ticks so the envelope gets
	// all the way down to its floor and bounces within one phase.
	function automatic logic [3:0] pick_elapsed(input bit pulse);
		if ($urandom_range(9) == 0)
			return 4'($urandom_range(15));
		if (pulse)
			return ($urandom_range(3) == 0) ? 4'($urandom_range(1, 9)) : 4'd10;
		return 4'($urandom_range(1, 10));
	endfunction

	// Random phases until roughly the given number of ticks has gone out.
	// Blink phases use short half periods and small cycle limits so that
	// toggles and forced-off endings happen often; a pulse phase is long
	// enough for about one full pass from the last table entry to the first.
	task automatic random_regime(input int unsigned target);
		int unsigned     sent;
		int unsigned     n;
		lbbp_pkg::mode_t mode;
		logic [15:0]     limit;
		logic [15:0]     half;
		bit              pulse;
		sent = 0;
		while (sent < target) begin
			pulse = ($urandom_range(3) == 0);
			if (pulse) begin
				mode = lbbp_pkg::MODE_PULSE;
				limit = 16'($urandom_range(2));
				n = 380;
			end else begin
				case ($urandom_range(3))
					0: mode = lbbp_pkg::MODE_OFF;
					1: mode = lbbp_pkg::MODE_ON;
					default: mode = lbbp_pkg::MODE_BLINK;
				endcase
				case ($urandom_range(5))
					0, 1: limit = 16'd0;
					2: limit = 16'hFFFF;
					default: limit = 16'($urandom_range(1, 5));
				endcase
				n = $urandom_range(20, 60);
			end
			half = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(30));
			drain();
			set_pattern(mode, 1'($urandom), limit, half);
			repeat (n) send_tick(pick_elapsed(pulse));
			sent += n;
		end
	endtask

	initial begin
		cfg_valid <= 1'b0;
		cfg_index <= lbbp_pkg::REG_PATTERN_MODE;
		cfg_data <= 16'd0;
		in_valid <= 1'b0;
		elapsed_ms <= 4'd0;
		hold_request = 1'b0;
		src_idle_pct = 11;
		sink_idle_pct = 60;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Out of reset the pattern is off and nothing was configured, so even
		// a zero-length and an over-cap tick must report dark and not done.
		send_tick(4'd0);
		send_tick(4'd15);
		send_tick(4'd1);

		// Steady on, including a tick beyond the cap.
		drain();
		set_pattern(lbbp_pkg::MODE_ON, 1'b0, 16'd0, lbbp_pkg::BLINK_HALF_RESET);
		send_tick(4'd10);
		send_tick(4'd11);

		// Zero half period toggles on every tick, even a zero-length one. With a
		// limit of two, the second on-to-off edge forces the pattern off and the
		// block must then report done.
		drain();
		set_pattern(lbbp_pkg::MODE_BLINK, 1'b0, 16'd2, 16'd0);
		send_tick(4'd0);
		repeat (4) send_tick(4'd1);

		// Largest half period and limit: nothing toggles, red channel.
		drain();
		set_pattern(lbbp_pkg::MODE_BLINK, 1'b1, 16'hFFFF, 16'hFFFF);
		send_tick(4'd15);
		send_tick(4'd8);

		// Pulse starts at the last entry of the green table; zero-length and over-cap
		// ticks in between.
		drain();
		set_pattern(lbbp_pkg::MODE_PULSE, 1'b0, 16'd0, 16'd1);
		send_tick(4'd0);
		send_tick(4'd10);
		send_tick(4'd12);

		// Red pulse with a one-cycle limit.
		drain();
		set_pattern(lbbp_pkg::MODE_PULSE, 1'b1, 16'd1, lbbp_pkg::BLINK_HALF_RESET);
		send_tick(4'd7);
		send_tick(4'd4);

		// Off by configuration is dark but not done.
		drain();
		set_pattern(lbbp_pkg::MODE_OFF, 1'b1, 16'd3, 16'd5);
		send_tick(4'd2);
		send_tick(4'd9);

		// Random traffic: a slow receiver, then a slow sender, then full speed.
		random_regime(700);
		src_idle_pct = 60;
		sink_idle_pct = 11;
		random_regime(700);
		// At full speed the receiver first stalls for a long stretch while the
		// sender keeps offering ticks, so the block backs up into the tick side.
		src_idle_pct = 0;
		sink_idle_pct = 0;
		drain();
		set_pattern(lbbp_pkg::MODE_BLINK, 1'b1, 16'd3, 16'd4);
		hold_request = 1'b1;
		repeat (40) send_tick(pick_elapsed(1'b0));
		random_regime(610);

		drain();
		repeat (4) @(posedge clk);
		if (drive_mismatches == 0 && awaited_count == 0)
			$display("led_blink_breathe_pattern_unit_test OK");
		else
			$display("led_blink_breathe_pattern_unit_test NOT OK");
		$finish;
	end

endmodule

FILE: sim.f
+incdir+src
src/lbbp_pkg.sv
src/lbbp_step_logic.sv
src/led_blink_breathe_pattern_unit.sv
dv/lbbp_drive_checker.sv
dv/led_blink_breathe_pattern_unit_test.sv
